// ----- rtl/hsvgrb_pkg.sv -----
// Shared types, constants and helpers for the HSV to GRB pixel packer.
`timescale 1ns / 1ps
`default_nettype none

package hsvgrb_pkg;

   localparam int unsigned ChanWidth  = 8;
   localparam int unsigned ShiftWidth = 3;
   localparam int unsigned WordWidth  = 3 * ChanWidth;
   localparam logic [ShiftWidth-1:0] DimShiftReset = 3'd5;
   localparam logic [ChanWidth-1:0]  ChanMax       = 8'd255;

   // Sixth of the colour wheel that a hue falls in.
   typedef enum logic [2:0] {
      SEXT_RED     = 3'd0,
      SEXT_YELLOW  = 3'd1,
      SEXT_GREEN   = 3'd2,
      SEXT_CYAN    = 3'd3,
      SEXT_BLUE    = 3'd4,
      SEXT_MAGENTA = 3'd5
   } sextant_type;

   typedef struct packed {
      logic [ChanWidth-1:0] hue;
      logic [ChanWidth-1:0] saturation;
      logic [ChanWidth-1:0] brightness;
      logic [ChanWidth-1:0] led_index;
   } req_type;

   typedef struct packed {
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
      logic [WordWidth-1:0] pixel_word;
      logic [ChanWidth-1:0] pixel_index;
   } rsp_type;

   // Word after the sextant split.
   typedef struct packed {
      sextant_type          sextant;
      logic [ChanWidth-1:0] rem_x6;
      logic [ChanWidth-1:0] sat;
      logic [ChanWidth-1:0] val;
      logic [ChanWidth-1:0] idx;
   } split_type;

   // Word with the p, q and t terms finished.
   typedef struct packed {
      sextant_type          sextant;
      logic                 grey;
      logic [ChanWidth-1:0] val;
      logic [ChanWidth-1:0] p;
      logic [ChanWidth-1:0] q;
      logic [ChanWidth-1:0] t;
      logic [ChanWidth-1:0] idx;
   } terms_type;

   // First hue of each sextant, the sextant width being 43.
   function automatic logic [ChanWidth-1:0] sextant_base(input sextant_type s);
      logic [ChanWidth-1:0] base;
      unique case (s)
         SEXT_RED:     base = 8'd0;
         SEXT_YELLOW:  base = 8'd43;
         SEXT_GREEN:   base = 8'd86;
         SEXT_CYAN:    base = 8'd129;
         SEXT_BLUE:    base = 8'd172;
         default:      base = 8'd215;
      endcase
      return base;
   endfunction

   // Upper byte of an 8 by 8 product, which is the truncating shift by 8.
   function automatic logic [ChanWidth-1:0] mul_hi(input logic [ChanWidth-1:0] a,
                                                  input logic [ChanWidth-1:0] b);
      logic [2*ChanWidth-1:0] prod;
      prod = (2*ChanWidth)'(a) * (2*ChanWidth)'(b);
      return prod[2*ChanWidth-1:ChanWidth];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/hsv_to_grb_pixel_packer_top.sv -----
// Top level of the HSV to GRB pixel packer: control register and pipeline.
//
// A pixel word is taken on req_data at every rising edge where start is high
// and busy is low. busy stays low, so a new word may enter in every cycle.
// The pipeline has four register stages: sextant split, first products,
// second products, and colour select with dimming and packing. The result
// appears on rsp_data from the pack stage register, with rsp_valid high
// for a single cycle. One result leaves per cycle at full rate.
// The receiver cannot hold results off, and the block never needs it to.
// rsp_data carries the undimmed red, green and blue, the packed GRB word
// with each channel shifted right by dim_shift, and the LED index.
// dim_shift is written through csr_valid/csr_ready/csr_wdata; csr_ready is
// always high. Change it only while no word is in flight.
// Synchronous reset empties the pipeline and sets dim_shift to 5.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_grb_pixel_packer_top (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     start,
   output logic                                    busy,
   input  hsvgrb_pkg::req_type                     req_data,
   output logic                                    rsp_valid,
   output hsvgrb_pkg::rsp_type                     rsp_data,
   input  wire                                     csr_valid,
   output logic                                    csr_ready,
   input  wire  [hsvgrb_pkg::ShiftWidth-1:0]       csr_wdata
);

   logic [hsvgrb_pkg::ShiftWidth-1:0] dim_shift_ff;
   logic [hsvgrb_pkg::ShiftWidth-1:0] dim_shift_in;
   logic                              split_valid;
   hsvgrb_pkg::split_type             split_word;
   logic                              terms_valid;
   hsvgrb_pkg::terms_type             terms_word;
   logic                              accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_comb begin
      dim_shift_in = dim_shift_ff;
      if (csr_valid && csr_ready) begin
         dim_shift_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_shift_ff <= hsvgrb_pkg::DimShiftReset;
      end else begin
         dim_shift_ff <= dim_shift_in;
      end
   end

   hsvgrb_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_word   (req_data),
      .out_valid (split_valid),
      .out_word  (split_word)
   );

   hsvgrb_terms u_terms (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_word   (split_word),
      .out_valid (terms_valid),
      .out_word  (terms_word)
   );

   hsvgrb_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (terms_valid),
      .in_word   (terms_word),
      .dim_shift (dim_shift_ff),
      .out_valid (rsp_valid),
      .out_word  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- rtl/hsvgrb_split.sv -----
// First stage: finds the hue sextant and the scaled remainder within it.
`timescale 1ns / 1ps
`default_nettype none

module hsvgrb_split (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   input  hsvgrb_pkg::req_type         in_word,
   output logic                        out_valid,
   output hsvgrb_pkg::split_type       out_word
);

   hsvgrb_pkg::sextant_type sextant;
   logic [5:0]              rem;
   logic [8:0]              rem_x6;
   logic [hsvgrb_pkg::ChanWidth-1:0] hue_off;
   logic                    valid_ff;
   hsvgrb_pkg::split_type   word_ff;
   hsvgrb_pkg::split_type   word_in;

   // Dividing by 43 reduces to five threshold compares on an 8-bit hue.
   always_comb begin
      priority if (in_word.hue >= 8'd215) begin
         sextant = hsvgrb_pkg::SEXT_MAGENTA;
      end else if (in_word.hue >= 8'd172) begin
         sextant = hsvgrb_pkg::SEXT_BLUE;
      end else if (in_word.hue >= 8'd129) begin
         sextant = hsvgrb_pkg::SEXT_CYAN;
      end else if (in_word.hue >= 8'd86) begin
         sextant = hsvgrb_pkg::SEXT_GREEN;
      end else if (in_word.hue >= 8'd43) begin
         sextant = hsvgrb_pkg::SEXT_YELLOW;
      end else begin
         sextant = hsvgrb_pkg::SEXT_RED;
      end
   end

   always_comb begin
      hue_off = in_word.hue - hsvgrb_pkg::sextant_base(sextant);
      rem     = hue_off[5:0];
      rem_x6  = ({3'b000, rem} << 2) + ({3'b000, rem} << 1);
      word_in.sextant = sextant;
      word_in.rem_x6  = rem_x6[7:0];
      word_in.sat     = in_word.saturation;
      word_in.val     = in_word.brightness;
      word_in.idx     = in_word.led_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

// ----- rtl/hsvgrb_terms.sv -----
// Second and third stages: the two levels of products that form p, q and t.
`timescale 1ns / 1ps
`default_nettype none

module hsvgrb_terms (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   input  hsvgrb_pkg::split_type       in_word,
   output logic                        out_valid,
   output hsvgrb_pkg::terms_type       out_word
);

   localparam int unsigned W = hsvgrb_pkg::ChanWidth;

   typedef struct packed {
      hsvgrb_pkg::sextant_type sextant;
      logic                    grey;
      logic [W-1:0]            val;
      logic [W-1:0]            p;
      logic [W-1:0]            q_fac;
      logic [W-1:0]            t_fac;
      logic [W-1:0]            idx;
   } fac_type;

   logic                    fac_valid_ff;
   fac_type                 fac_ff;
   fac_type                 fac_in;
   logic                    terms_valid_ff;
   hsvgrb_pkg::terms_type   terms_ff;
   hsvgrb_pkg::terms_type   terms_in;

   // First level: p and the factors that q and t scale the value by.
   always_comb begin
      fac_in.sextant = in_word.sextant;
      fac_in.grey    = (in_word.sat == '0);
      fac_in.val     = in_word.val;
      fac_in.p       = hsvgrb_pkg::mul_hi(in_word.val, hsvgrb_pkg::ChanMax - in_word.sat);
      fac_in.q_fac   = hsvgrb_pkg::ChanMax
                       - hsvgrb_pkg::mul_hi(in_word.sat, in_word.rem_x6);
      fac_in.t_fac   = hsvgrb_pkg::ChanMax
                       - hsvgrb_pkg::mul_hi(in_word.sat,
                                            hsvgrb_pkg::ChanMax - in_word.rem_x6);
      fac_in.idx     = in_word.idx;
   end

   // Second level: scale the value by the factors.
   always_comb begin
      terms_in.sextant = fac_ff.sextant;
      terms_in.grey    = fac_ff.grey;
      terms_in.val     = fac_ff.val;
      terms_in.p       = fac_ff.p;
      terms_in.q       = hsvgrb_pkg::mul_hi(fac_ff.val, fac_ff.q_fac);
      terms_in.t       = hsvgrb_pkg::mul_hi(fac_ff.val, fac_ff.t_fac);
      terms_in.idx     = fac_ff.idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fac_valid_ff   <= 1'b0;
         terms_valid_ff <= 1'b0;
      end else begin
         fac_valid_ff   <= in_valid;
         terms_valid_ff <= fac_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      fac_ff   <= fac_in;
      terms_ff <= terms_in;
   end

   assign out_valid = terms_valid_ff;
   assign out_word  = terms_ff;

endmodule

`default_nettype wire

// ----- rtl/hsvgrb_pack.sv -----
// Last stage: picks red, green and blue, dims them and packs the GRB word.
`timescale 1ns / 1ps
`default_nettype none

module hsvgrb_pack (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     in_valid,
   input  hsvgrb_pkg::terms_type                   in_word,
   input  wire  [hsvgrb_pkg::ShiftWidth-1:0]       dim_shift,
   output logic                                    out_valid,
   output hsvgrb_pkg::rsp_type                     out_word
);

   localparam int unsigned W = hsvgrb_pkg::ChanWidth;

   logic [W-1:0]          red;
   logic [W-1:0]          green;
   logic [W-1:0]          blue;
   logic                  valid_ff;
   hsvgrb_pkg::rsp_type   word_ff;
   hsvgrb_pkg::rsp_type   word_in;

   always_comb begin
      if (in_word.grey) begin
         red   = in_word.val;
         green = in_word.val;
         blue  = in_word.val;
      end else begin
         unique case (in_word.sextant)
            hsvgrb_pkg::SEXT_RED: begin
               red = in_word.val; green = in_word.t;   blue = in_word.p;
            end
            hsvgrb_pkg::SEXT_YELLOW: begin
               red = in_word.q;   green = in_word.val; blue = in_word.p;
            end
            hsvgrb_pkg::SEXT_GREEN: begin
               red = in_word.p;   green = in_word.val; blue = in_word.t;
            end
            hsvgrb_pkg::SEXT_CYAN: begin
               red = in_word.p;   green = in_word.q;   blue = in_word.val;
            end
            hsvgrb_pkg::SEXT_BLUE: begin
               red = in_word.t;   green = in_word.p;   blue = in_word.val;
            end
            default: begin
               red = in_word.val; green = in_word.p;   blue = in_word.q;
            end
         endcase
      end
   end

   always_comb begin
      word_in.red         = red;
      word_in.green       = green;
      word_in.blue        = blue;
      word_in.pixel_word  = {green >> dim_shift, red >> dim_shift, blue >> dim_shift};
      word_in.pixel_index = in_word.idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire
